@@ rtl/cmrp_pkg.sv @@
// shared types and constants for the clipmap ring patch generator
`timescale 1ns / 1ps
package cmrp_pkg;

	// field widths
	localparam int CAM_W  = 24;
	localparam int POS_W  = 16;
	localparam int RING_W = 4;
	localparam int LG_W   = 5;
	localparam int ROT_W  = 3;
	localparam int KIND_W = 2;
	localparam int RCNT_W = 5;
	localparam int HW_W   = 7;
	localparam int BLG_W  = 4;

	// wide signed work width for snap and ring extents
	localparam int SNAP_W = 41;
	// width of a position plus a patch edge
	localparam int SUM_W  = 32;

	// most rings per camera update
	localparam logic [RCNT_W-1:0] MAX_RINGS = 5'd16;

	// register indexes
	localparam logic [1:0] REG_BASE_SCALE = 2'd0;
	localparam logic [1:0] REG_MAX_GRID   = 2'd1;
	localparam logic [1:0] REG_RING_COUNT = 2'd2;
	localparam logic [1:0] REG_HALF_WIDTH = 2'd3;

	// input operations
	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	// orientation codes
	localparam logic [ROT_W-1:0] ROT_TOP          = 3'd0;
	localparam logic [ROT_W-1:0] ROT_BOTTOM       = 3'd1;
	localparam logic [ROT_W-1:0] ROT_NONE         = 3'd2;
	localparam logic [ROT_W-1:0] ROT_LEFT         = 3'd3;
	localparam logic [ROT_W-1:0] ROT_BOTTOM_RIGHT = 3'd4;

	// patch kinds
	localparam logic [KIND_W-1:0] KIND_FULL   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EDGE   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CORNER = 2'd2;

	// configuration registers
	typedef struct packed {
		logic [BLG_W-1:0]  base_log2;
		logic [POS_W-1:0]  max_grid;
		logic [RCNT_W-1:0] ring_count;
		logic [HW_W-1:0]   half_width;
	} cfg_t;

	// square of one ring
	typedef struct packed {
		logic [POS_W-1:0] min_x;
		logic [POS_W-1:0] min_y;
		logic [POS_W-1:0] max_x;
		logic [POS_W-1:0] max_y;
	} bounds_t;

endpackage

@@ rtl/cmrp_ring_bounds.sv @@
// clamped square of one ring from the camera and the ring scale
`timescale 1ns / 1ps
module cmrp_ring_bounds #(
	parameter int FRAC_BITS = 8
) (
	input  cmrp_pkg::cfg_t                      cfg,
	input  logic [cmrp_pkg::RING_W-1:0]         ring,
	input  logic signed [cmrp_pkg::CAM_W-1:0]   cam_x,
	input  logic signed [cmrp_pkg::CAM_W-1:0]   cam_z,
	output cmrp_pkg::bounds_t                   bounds
);

	localparam int SW = cmrp_pkg::SNAP_W;

	logic [cmrp_pkg::LG_W-1:0] lg;
	logic [cmrp_pkg::LG_W-1:0] lg_p1;
	logic signed [SW-1:0]      cx_fl;
	logic signed [SW-1:0]      cz_fl;
	logic [SW-1:0]             low_mask;
	logic signed [SW-1:0]      snap_x;
	logic signed [SW-1:0]      snap_z;
	logic [SW-1:0]             half_u;
	logic signed [SW-1:0]      half;

	// clamp a signed extent into zero to max_grid
	function automatic logic [cmrp_pkg::POS_W-1:0] clamp_grid(
		input logic signed [SW-1:0] v,
		input logic [cmrp_pkg::POS_W-1:0] mg
	);
		logic signed [SW-1:0] mg_w;
		mg_w = $signed({{(SW-cmrp_pkg::POS_W){1'b0}}, mg});
		if (v < 0) begin
			return '0;
		end else if (v > mg_w) begin
			return mg;
		end
		return v[cmrp_pkg::POS_W-1:0];
	endfunction

	// patch edge is 2^lg, snap to a multiple of twice that
	assign lg    = {1'b0, cfg.base_log2} + {1'b0, ring};
	assign lg_p1 = lg + cmrp_pkg::LG_W'(1);

	// floor to whole world units
	assign cx_fl = SW'(cam_x) >>> FRAC_BITS;
	assign cz_fl = SW'(cam_z) >>> FRAC_BITS;

	// clearing low bits floors toward minus infinity
	assign low_mask = (SW'(1) << lg_p1) - SW'(1);
	assign snap_x   = cx_fl & $signed(~low_mask);
	assign snap_z   = cz_fl & $signed(~low_mask);

	// half width in world units
	assign half_u = {{(SW-cmrp_pkg::HW_W){1'b0}}, cfg.half_width} << lg;
	assign half   = $signed(half_u);

	assign bounds.min_x = clamp_grid(snap_x - half, cfg.max_grid);
	assign bounds.min_y = clamp_grid(snap_z - half, cfg.max_grid);
	assign bounds.max_x = clamp_grid(snap_x + half, cfg.max_grid);
	assign bounds.max_y = clamp_grid(snap_z + half, cfg.max_grid);

endmodule

@@ rtl/clipmap_ring_patch_generator.sv @@
// top level of the clipmap ring patch generator
`timescale 1ns / 1ps
// Walks the patches of a terrain clipmap around a camera, one grid position per item.
// Input stream (s_*): tuser is the op (start or step), tdata carries cam_x and cam_z.
// A start item latches the camera and enters ring 0; each step item visits one
// position of the current ring. Every input item gives exactly one output item.
// Output stream (m_*): tuser says the item carries a patch, tlast marks the item
// after which all rings are exhausted; tdata holds position, ring, rotation, kind.
// Each item passes through the input register and then the output register.
// Throughput: one item per cycle while the receiver does not stall; the walk state and the
// result register are updated at the same edge and the ring square logic is combinational,
// so the only loop is the update of the walk registers.
// When the receiver stalls the output register holds its item; one more item
// waits in the input register and s_tready drops until the output is taken.
// Reset (arst_n low) clears the walk: the block is idle until a start item,
// and the registers return to their documented defaults. Configuration goes through the
// APB port, one register per word at 4*index; the user must write it only while no item
// is in flight, which the block does not enforce; patch size and ring count apply at once.
module clipmap_ring_patch_generator #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // cam_x [23:0], cam_z [47:24]
	input  logic        s_tuser,   // op
	// output items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // pos_x, pos_y, ring_index, rotation, patch_kind, zero pad
	output logic        m_tuser,   // valid_res
	output logic        m_tlast,   // done_res
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int PW = cmrp_pkg::POS_W;
	localparam int CW = cmrp_pkg::CAM_W;
	localparam int RW = cmrp_pkg::RING_W;
	localparam int UW = cmrp_pkg::SUM_W;
	localparam logic [PW-1:0] POS_MASK = (COORD_BITS >= PW) ? {PW{1'b1}} :
		PW'((64'd1 << COORD_BITS) - 64'd1);

	// configuration registers
	cmrp_pkg::cfg_t cfg_q;
	logic           cfg_wr;
	logic [1:0]     cfg_idx;

	// input stage
	logic                 in_valid_s1;
	logic                 in_op_s1;
	logic signed [CW-1:0] in_cam_x_s1;
	logic signed [CW-1:0] in_cam_z_s1;
	logic                 advance;

	// walk state
	logic                 active_q;
	logic [RW-1:0]        ring_now_q;
	logic [PW-1:0]        walk_x_q;
	logic [PW-1:0]        walk_y_q;
	cmrp_pkg::bounds_t    ring_b_q;
	cmrp_pkg::bounds_t    prior_b_q;
	logic signed [CW-1:0] cam_x_q;
	logic signed [CW-1:0] cam_z_q;

	// next walk state
	logic                 active_d;
	logic [RW-1:0]        ring_now_d;
	logic [PW-1:0]        walk_x_d;
	logic [PW-1:0]        walk_y_d;
	cmrp_pkg::bounds_t    ring_b_d;
	cmrp_pkg::bounds_t    prior_b_d;
	logic signed [CW-1:0] cam_x_d;
	logic signed [CW-1:0] cam_z_d;

	// result of the item in the input stage
	logic                         res_patch;
	logic [PW-1:0]                res_pos_x;
	logic [PW-1:0]                res_pos_y;
	logic [RW-1:0]                res_ring;
	logic [cmrp_pkg::ROT_W-1:0]   res_rot;
	logic [cmrp_pkg::KIND_W-1:0]  res_kind;
	logic                         res_done;

	// output register
	logic                         out_valid_s2;
	logic                         out_patch_s2;
	logic [PW-1:0]                out_pos_x_s2;
	logic [PW-1:0]                out_pos_y_s2;
	logic [RW-1:0]                out_ring_s2;
	logic [cmrp_pkg::ROT_W-1:0]   out_rot_s2;
	logic [cmrp_pkg::KIND_W-1:0]  out_kind_s2;
	logic                         out_done_s2;

	// ring square unit
	logic [RW-1:0]              bnd_ring;
	logic signed [CW-1:0]       bnd_cam_x;
	logic signed [CW-1:0]       bnd_cam_z;
	cmrp_pkg::bounds_t          bnd_new;

	// walk helpers
	logic [cmrp_pkg::RCNT_W-1:0] limit;
	logic [cmrp_pkg::RCNT_W-1:0] ring_next;
	logic [cmrp_pkg::LG_W-1:0]   lg_now;
	logic [UW-1:0]               scale;
	logic [UW-1:0]               x_plus;
	logic [UW-1:0]               y_plus;

	// apb access
	assign pready  = 1'b1;
	assign cfg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_log2  <= '0;
			cfg_q.max_grid   <= 16'd4096;
			cfg_q.ring_count <= 5'd8;
			cfg_q.half_width <= 7'd8;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				cmrp_pkg::REG_BASE_SCALE: cfg_q.base_log2  <= pwdata[cmrp_pkg::BLG_W-1:0];
				cmrp_pkg::REG_MAX_GRID:   cfg_q.max_grid   <= pwdata[PW-1:0];
				cmrp_pkg::REG_RING_COUNT: cfg_q.ring_count <= pwdata[cmrp_pkg::RCNT_W-1:0];
				cmrp_pkg::REG_HALF_WIDTH: cfg_q.half_width <= pwdata[cmrp_pkg::HW_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			cmrp_pkg::REG_BASE_SCALE: prdata = 32'(cfg_q.base_log2);
			cmrp_pkg::REG_MAX_GRID:   prdata = 32'(cfg_q.max_grid);
			cmrp_pkg::REG_RING_COUNT: prdata = 32'(cfg_q.ring_count);
			cmrp_pkg::REG_HALF_WIDTH: prdata = 32'(cfg_q.half_width);
		endcase
	end

	// handshake: the input stage moves on when the output register is free
	assign advance  = in_valid_s1 && (!out_valid_s2 || m_tready);
	assign s_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_op_s1    <= s_tuser;
			in_cam_x_s1 <= $signed(s_tdata[CW-1:0]);
			in_cam_z_s1 <= $signed(s_tdata[2*CW-1:CW]);
		end
	end

	// ring square for the ring being entered
	assign ring_next = {1'b0, ring_now_q} + cmrp_pkg::RCNT_W'(1);
	assign bnd_ring  = (in_op_s1 == cmrp_pkg::OP_STEP) ? ring_next[RW-1:0] : '0;
	assign bnd_cam_x = (in_op_s1 == cmrp_pkg::OP_STEP) ? cam_x_q : in_cam_x_s1;
	assign bnd_cam_z = (in_op_s1 == cmrp_pkg::OP_STEP) ? cam_z_q : in_cam_z_s1;

	cmrp_ring_bounds #(
		.FRAC_BITS (FRAC_BITS)
	) u_bounds (
		.cfg    (cfg_q),
		.ring   (bnd_ring),
		.cam_x  (bnd_cam_x),
		.cam_z  (bnd_cam_z),
		.bounds (bnd_new)
	);

	// ring limit, patch edge and the next grid positions
	assign limit  = (cfg_q.ring_count > cmrp_pkg::MAX_RINGS) ? cmrp_pkg::MAX_RINGS :
		cfg_q.ring_count;
	assign lg_now = {1'b0, cfg_q.base_log2} + {1'b0, ring_now_q};
	assign scale  = UW'(1) << lg_now;
	assign x_plus = UW'(walk_x_q) + scale;
	assign y_plus = UW'(walk_y_q) + scale;

	// one walk step
	always_comb begin
		logic do_next;
		logic empty;
		logic in_prior;
		logic xmin;
		logic xmax;
		logic ymin;
		logic ymax;

		active_d   = active_q;
		ring_now_d = ring_now_q;
		walk_x_d   = walk_x_q;
		walk_y_d   = walk_y_q;
		ring_b_d   = ring_b_q;
		prior_b_d  = prior_b_q;
		cam_x_d    = cam_x_q;
		cam_z_d    = cam_z_q;
		res_patch  = 1'b0;
		res_pos_x  = '0;
		res_pos_y  = '0;
		res_ring   = '0;
		res_rot    = '0;
		res_kind   = '0;
		res_done   = 1'b0;
		do_next    = 1'b0;

		empty    = (ring_b_q.min_x >= ring_b_q.max_x) || (ring_b_q.min_y >= ring_b_q.max_y);
		in_prior = (walk_x_q >= prior_b_q.min_x) && (walk_y_q >= prior_b_q.min_y) &&
			(walk_x_q < prior_b_q.max_x) && (walk_y_q < prior_b_q.max_y);
		ymin     = (walk_y_q == ring_b_q.min_y);
		ymax     = !ymin && (y_plus >= UW'(ring_b_q.max_y));
		xmin     = (walk_x_q == ring_b_q.min_x);
		xmax     = !xmin && (x_plus >= UW'(ring_b_q.max_x));

		if (in_op_s1 == cmrp_pkg::OP_START) begin
			// latch camera and restart at ring zero
			cam_x_d   = in_cam_x_s1;
			cam_z_d   = in_cam_z_s1;
			prior_b_d = '0;
			if (limit == '0) begin
				active_d   = 1'b0;
				ring_now_d = '0;
				res_done   = 1'b1;
			end else begin
				active_d   = 1'b1;
				ring_b_d   = bnd_new;
				ring_now_d = '0;
				walk_x_d   = bnd_new.min_x;
				walk_y_d   = bnd_new.min_y;
			end
		end else if (!active_q) begin
			res_done = 1'b1;
		end else if (empty) begin
			do_next = 1'b1;
		end else begin
			// classify a position outside the previous ring
			if (!in_prior) begin
				res_patch = 1'b1;
				res_pos_x = walk_x_q & POS_MASK;
				res_pos_y = walk_y_q & POS_MASK;
				res_ring  = ring_now_q;
				priority if (ymin) begin
					res_rot = xmax ? cmrp_pkg::ROT_BOTTOM_RIGHT : cmrp_pkg::ROT_BOTTOM;
				end else if (xmin) begin
					res_rot = cmrp_pkg::ROT_LEFT;
				end else if (ymax) begin
					res_rot = cmrp_pkg::ROT_TOP;
				end else begin
					res_rot = cmrp_pkg::ROT_NONE;
				end
				priority if (!(xmin || xmax) && !(ymin || ymax)) begin
					res_kind = cmrp_pkg::KIND_FULL;
				end else if (!(xmin || xmax) || !(ymin || ymax)) begin
					res_kind = cmrp_pkg::KIND_EDGE;
				end else begin
					res_kind = cmrp_pkg::KIND_CORNER;
				end
			end
			// y inner, x outer
			if (y_plus < UW'(ring_b_q.max_y)) begin
				walk_y_d = y_plus[PW-1:0];
			end else begin
				walk_y_d = ring_b_q.min_y;
				if (x_plus < UW'(ring_b_q.max_x)) begin
					walk_x_d = x_plus[PW-1:0];
				end else begin
					do_next = 1'b1;
				end
			end
		end

		// move on to the next ring or finish
		if (do_next) begin
			prior_b_d = ring_b_q;
			if (ring_next >= limit) begin
				active_d = 1'b0;
				res_done = 1'b1;
			end else begin
				ring_b_d   = bnd_new;
				ring_now_d = ring_next[RW-1:0];
				walk_x_d   = bnd_new.min_x;
				walk_y_d   = bnd_new.min_y;
			end
		end
	end

	// walk state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			ring_now_q <= '0;
			walk_x_q   <= '0;
			walk_y_q   <= '0;
			ring_b_q   <= '0;
			prior_b_q  <= '0;
			cam_x_q    <= '0;
			cam_z_q    <= '0;
		end else if (advance) begin
			active_q   <= active_d;
			ring_now_q <= ring_now_d;
			walk_x_q   <= walk_x_d;
			walk_y_q   <= walk_y_d;
			ring_b_q   <= ring_b_d;
			prior_b_q  <= prior_b_d;
			cam_x_q    <= cam_x_d;
			cam_z_q    <= cam_z_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_patch_s2 <= res_patch;
			out_pos_x_s2 <= res_pos_x;
			out_pos_y_s2 <= res_pos_y;
			out_ring_s2  <= res_ring;
			out_rot_s2   <= res_rot;
			out_kind_s2  <= res_kind;
			out_done_s2  <= res_done;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tuser  = out_patch_s2;
	assign m_tlast  = out_done_s2;
	assign m_tdata  = {7'b0, out_kind_s2, out_rot_s2, out_ring_s2, out_pos_y_s2, out_pos_x_s2};

`ifndef SYNTHESIS
	// an item without a patch carries all-zero data
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("patch fields set on an item without a patch");

	// a step while idle yields a done item without a patch
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && (in_op_s1 == cmrp_pkg::OP_STEP) && !active_q |=>
		m_tvalid && m_tlast && !m_tuser)
		else $error("idle step did not report done");

	// full patches are never rotated, corner stitches always are
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && (out_kind_s2 == cmrp_pkg::KIND_FULL) |->
		out_rot_s2 == cmrp_pkg::ROT_NONE)
		else $error("full patch with a rotation");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && (out_kind_s2 == cmrp_pkg::KIND_CORNER) |->
		out_rot_s2 != cmrp_pkg::ROT_NONE)
		else $error("corner stitch without a rotation");
`endif

endmodule
